>>> hw/rtl/afrc_pkg.sv
package afrc_pkg;

    // Fixed frame bytes.
    localparam logic [7:0] FRAME_SYNC = 8'h51;
    localparam logic [7:0] FRAME_HDB2 = 8'h41;
    localparam logic [7:0] FRAME_SRC  = 8'h00;
    localparam logic [7:0] FRAME_HDB1 = 8'h02;

    // Reflected CRC-16 polynomial and start value.
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // Node address after reset.
    localparam logic [7:0] NODE_ADDR_RESET = 8'd27;

    // One frame verdict as it travels from the parser to the result register.
    typedef struct packed {
        logic        crc_ok;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
    } afrc_result_t;

    // One byte of a reflected CRC-16, least significant bit first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        logic [7:0]  b;
        logic        lsb;
        crc = crc_in;
        b   = data;
        for (int k = 0; k < 8; k++) begin
            lsb = crc[0] ^ b[0];
            crc = crc >> 1;
            if (lsb) begin
                crc = crc ^ CRC_POLY;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

endpackage

>>> hw/rtl/addressed_frame_receiver_crc16_unit.sv
// Frame receiver for seven-byte addressed frames (0x51, 0x41, node address, 0x00,
// 0x02, CRC high, CRC low) with a CRC-16/ARC check over the five header bytes. It
// takes one byte per cycle unless the result register is full and not being read:
// each byte is held in an input register, judged by the parser and its one-byte CRC
// XOR network once the result register has room, and a frame verdict is held in a
// result register that drives m_valid. A byte that breaks the header is dropped and
// the parser returns to idle. The node address is written through cfg_wr_en and
// cfg_wr_data, resets to 27, and should be changed only while no frame is in flight.
module addressed_frame_receiver_crc16_unit
    import afrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_crc_ok,
    output logic [15:0] m_computed_crc,
    output logic [15:0] m_received_crc
);

    logic [7:0]   node_address_reg;
    logic         byte_valid;
    logic [7:0]   byte_data;
    logic         out_free;
    logic         take;
    logic         res_valid;
    afrc_result_t res;

    // Node address register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_address_reg <= NODE_ADDR_RESET;
        end else if (cfg_wr_en) begin
            node_address_reg <= cfg_wr_data;
        end
    end

    // A held byte is processed whenever the result register has room.
    assign take = byte_valid && out_free;

    afrc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    afrc_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (take),
        .byte_data    (byte_data),
        .node_address (node_address_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    afrc_out_reg u_out_reg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (res_valid),
        .res            (res),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_crc_ok       (m_crc_ok),
        .m_computed_crc (m_computed_crc),
        .m_received_crc (m_received_crc)
    );

endmodule

>>> hw/rtl/afrc_in_reg.sv
module afrc_in_reg
    import afrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The register can take a new transfer when empty or when its byte leaves now.
    assign s_ready    = !valid_reg || take;
    assign valid_next = s_valid || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= valid_next;
        end
    end

    // Payload is loaded on each accepted transfer.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

>>> hw/rtl/afrc_parser.sv
module afrc_parser
    import afrc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         take,
    input  logic [7:0]   byte_data,
    input  logic [7:0]   node_address,
    output logic         res_valid,
    output afrc_result_t res
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SYNC = 3'd1,
        PH_HDB2 = 3'd2,
        PH_ADDR = 3'd3,
        PH_SRC  = 3'd4,
        PH_CRCH = 3'd5,
        PH_CRCL = 3'd6
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  crc_high_reg;
    logic [7:0]  crc_high_next;
    logic [15:0] crc_upd;
    logic [15:0] rx_crc;

    // CRC update for the byte in hand; a frame start restarts from the initial value.
    assign crc_upd = crc16_byte((phase_reg == PH_IDLE) ? CRC_INIT : crc_reg, byte_data);
    assign rx_crc  = {crc_high_reg, byte_data};

    // Next phase and result for the byte being taken.
    always_comb begin
        phase_next    = PH_IDLE;
        crc_next      = crc_reg;
        crc_high_next = crc_high_reg;
        res_valid     = 1'b0;
        case (phase_reg)
            PH_IDLE: begin
                if (byte_data == FRAME_SYNC) begin
                    crc_next   = crc_upd;
                    phase_next = PH_SYNC;
                end
            end
            PH_SYNC: begin
                if (byte_data == FRAME_HDB2) begin
                    crc_next   = crc_upd;
                    phase_next = PH_HDB2;
                end
            end
            PH_HDB2: begin
                if (byte_data == node_address) begin
                    crc_next   = crc_upd;
                    phase_next = PH_ADDR;
                end
            end
            PH_ADDR: begin
                if (byte_data == FRAME_SRC) begin
                    crc_next   = crc_upd;
                    phase_next = PH_SRC;
                end
            end
            PH_SRC: begin
                if (byte_data == FRAME_HDB1) begin
                    crc_next   = crc_upd;
                    phase_next = PH_CRCH;
                end
            end
            PH_CRCH: begin
                crc_high_next = byte_data;
                phase_next    = PH_CRCL;
            end
            PH_CRCL: begin
                res_valid  = take;
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign res.crc_ok       = (rx_crc == crc_reg);
    assign res.computed_crc = crc_reg;
    assign res.received_crc = rx_crc;

    // Parser state advances only when a byte is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            crc_reg      <= CRC_INIT;
            crc_high_reg <= 8'h00;
        end else if (take) begin
            phase_reg    <= phase_next;
            crc_reg      <= crc_next;
            crc_high_reg <= crc_high_next;
        end
    end

endmodule

>>> hw/rtl/afrc_out_reg.sv
module afrc_out_reg
    import afrc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  afrc_result_t res,
    output logic         out_free,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_crc_ok,
    output logic [15:0]  m_computed_crc,
    output logic [15:0]  m_received_crc
);

    logic         valid_reg;
    logic         valid_next;
    afrc_result_t res_reg;

    // A slot is free when empty or when the held result is taken this cycle.
    assign out_free   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid        = valid_reg;
    assign m_crc_ok       = res_reg.crc_ok;
    assign m_computed_crc = res_reg.computed_crc;
    assign m_received_crc = res_reg.received_crc;

endmodule
